@@ rtl/gpfl_pkg.sv @@
// Shared types, constants and helper functions of the gated PI frequency lock.
`default_nettype none

package gpfl_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_ON     = 2'd1,
    REQ_OFF    = 2'd2,
    REQ_MANUAL = 2'd3
  } req_e;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_SETPOINT = 3'd0;
  localparam logic [2:0] REG_MAX_ERR  = 3'd1;
  localparam logic [2:0] REG_GAIN_P   = 3'd2;
  localparam logic [2:0] REG_GAIN_I   = 3'd3;
  localparam logic [2:0] REG_CORR_MIN = 3'd4;
  localparam logic [2:0] REG_CORR_MAX = 3'd5;
  localparam logic [2:0] REG_SETTLE   = 3'd6;

  localparam int unsigned ADDR_W = 5;

  // Integral product magnitude cap, 2^62.
  localparam logic [64:0] PROD_CAP = 65'h0_4000_0000_0000_0000;

  // Half an mV in Q.24, added before the floor shift.
  localparam logic signed [65:0] ROUND_HALF = 66'sd8388608;

  localparam logic signed [15:0] DAC_LIMIT = 16'sd10000;

  typedef struct packed {
    logic        [29:0] setpoint;
    logic        [19:0] max_err;
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [14:0] corr_min;
    logic signed [14:0] corr_max;
    logic        [15:0] settle;
  } cfg_t;

  // Per-item control that travels down to the output stage.
  typedef struct packed {
    req_e               req;
    logic               applied;
    logic               capture;
    logic               refused;
    logic               locked;
    logic               regulating;
    logic signed [14:0] manual;
  } ctl_t;

  // Contents of the accept-stage register.
  typedef struct packed {
    ctl_t               ctl;
    logic signed [30:0] err;
    logic signed [63:0] sum;
  } stage_a_t;

  // Contents of the last product stage.
  typedef struct packed {
    ctl_t               ctl;
    logic signed [63:0] integ;
    logic signed [62:0] prop;
  } prod_t;

  // Saturate a voltage to the DAC range.
  function automatic logic signed [14:0] sat_dac(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > DAC_LIMIT) begin
      r = DAC_LIMIT;
    end else if (v < -DAC_LIMIT) begin
      r = -DAC_LIMIT;
    end
    return r[14:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/gpfl_regs.sv @@
// APB configuration register file of the gated PI frequency lock.
`default_nettype none

module gpfl_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gpfl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output gpfl_pkg::cfg_t                  cfg_o
);

  gpfl_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        gpfl_pkg::REG_SETPOINT: cfg_q.setpoint <= pwdata[29:0];
        gpfl_pkg::REG_MAX_ERR:  cfg_q.max_err  <= pwdata[19:0];
        gpfl_pkg::REG_GAIN_P:   cfg_q.gain_p   <= pwdata;
        gpfl_pkg::REG_GAIN_I:   cfg_q.gain_i   <= pwdata;
        gpfl_pkg::REG_CORR_MIN: cfg_q.corr_min <= pwdata[14:0];
        gpfl_pkg::REG_CORR_MAX: cfg_q.corr_max <= pwdata[14:0];
        gpfl_pkg::REG_SETTLE:   cfg_q.settle   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gpfl_pkg::REG_SETPOINT: prdata = {2'd0, cfg_q.setpoint};
      gpfl_pkg::REG_MAX_ERR:  prdata = {12'd0, cfg_q.max_err};
      gpfl_pkg::REG_GAIN_P:   prdata = cfg_q.gain_p;
      gpfl_pkg::REG_GAIN_I:   prdata = cfg_q.gain_i;
      gpfl_pkg::REG_CORR_MIN: prdata = 32'(cfg_q.corr_min);
      gpfl_pkg::REG_CORR_MAX: prdata = 32'(cfg_q.corr_max);
      gpfl_pkg::REG_SETTLE:   prdata = {16'd0, cfg_q.settle};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/gpfl_ctrl.sv @@
// Accept stage: error, lock window, good counter, error sum and regulation state.
`default_nettype none

module gpfl_ctrl #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SUM_BITS   = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gpfl_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gpfl_pkg::req_e     req_i,
  input  wire logic        [29:0] freq_i,
  input  wire logic signed [14:0] manual_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gpfl_pkg::stage_a_t      out_o
);

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic [COUNT_BITS-1:0]      cnt_q, cnt_d;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;
  logic                       reg_on_q, reg_on_d;
  logic                       lock_q, lock_d;
  logic                       valid_q;
  gpfl_pkg::stage_a_t         data_q, data_d;

  logic signed [30:0] err;
  logic [30:0]        err_u, aerr;
  logic [30:0]        max_ext;
  logic               good, refused, capture, applied;
  logic signed [SUM_BITS:0] sum_wide;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic               accept;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  assign err     = $signed({1'b0, freq_i}) - $signed({1'b0, cfg_i.setpoint});
  assign err_u   = err;
  assign aerr    = err_u[30] ? (31'd0 - err_u) : err_u;
  assign max_ext = {11'd0, cfg_i.max_err};
  assign good    = aerr < max_ext;

  // Saturating add of the error into the sum; the error is small whenever it is added.
  assign sum_wide = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(err);
  always_comb begin
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    reg_on_d = reg_on_q;
    lock_d   = lock_q;
    refused  = 1'b0;
    capture  = 1'b0;
    applied  = 1'b0;
    case (req_i)
      gpfl_pkg::REQ_SAMPLE: begin
        if (reg_on_q) begin
          if (good) begin
            cnt_d  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
            sum_d  = sum_sat;
            lock_d = 1'b1;
          end else begin
            cnt_d  = '0;
            sum_d  = '0;
            lock_d = 1'b0;
          end
          applied = 32'(cnt_d) >= 32'(cfg_i.settle);
        end
      end
      gpfl_pkg::REQ_ON: begin
        if (!reg_on_q) begin
          if (aerr > max_ext) begin
            refused = 1'b1;
          end else begin
            reg_on_d = 1'b1;
            capture  = 1'b1;
          end
        end
      end
      gpfl_pkg::REQ_OFF: begin
        reg_on_d = 1'b0;
        lock_d   = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    data_d.ctl.req        = req_i;
    data_d.ctl.applied    = applied;
    data_d.ctl.capture    = capture;
    data_d.ctl.refused    = refused;
    data_d.ctl.locked     = lock_d;
    data_d.ctl.regulating = reg_on_d;
    data_d.ctl.manual     = manual_i;
    data_d.err            = err;
    data_d.sum            = 64'(sum_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      reg_on_q <= 1'b0;
      lock_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q    <= cnt_d;
        sum_q    <= sum_d;
        reg_on_q <= reg_on_d;
        lock_q   <= lock_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gpfl_mult.sv @@
// Product stages: capped integral product in two 32-bit halves and proportional product.
`default_nettype none

module gpfl_mult (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gpfl_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gpfl_pkg::stage_a_t in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gpfl_pkg::prod_t         out_o
);

  typedef struct packed {
    gpfl_pkg::ctl_t     ctl;
    logic signed [30:0] err;
    logic        [31:0] sum_hi;
    logic        [31:0] gain_mag;
    logic               neg;
    logic        [63:0] lo;
  } lo_t;

  typedef struct packed {
    gpfl_pkg::ctl_t     ctl;
    logic signed [30:0] err;
    logic               neg;
    logic        [63:0] hi;
    logic        [63:0] lo;
  } hi_t;

  logic            v1_q, v2_q, v3_q;
  logic            r1, r2, r3;
  lo_t             s1_q, s1_d;
  hi_t             s2_q, s2_d;
  gpfl_pkg::prod_t s3_q, s3_d;

  logic [63:0] sum_u, sum_mag;
  logic [31:0] gain_u;
  logic [64:0] p_sum;
  logic [64:0] p_cap;

  assign r3 = !v3_q || out_ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o  = r1;
  assign out_valid_o = v3_q;
  assign out_o       = s3_q;

  // Stage 1: magnitudes and the low partial product.
  assign sum_u   = in_i.sum;
  assign sum_mag = sum_u[63] ? (64'd0 - sum_u) : sum_u;
  assign gain_u  = cfg_i.gain_i;
  always_comb begin
    s1_d.ctl      = in_i.ctl;
    s1_d.err      = in_i.err;
    s1_d.sum_hi   = sum_mag[63:32];
    s1_d.gain_mag = gain_u[31] ? (32'd0 - gain_u) : gain_u;
    s1_d.neg      = sum_u[63] ^ gain_u[31];
    s1_d.lo       = sum_mag[31:0] * s1_d.gain_mag;
  end

  // Stage 2: the high partial product.
  always_comb begin
    s2_d.ctl = s1_q.ctl;
    s2_d.err = s1_q.err;
    s2_d.neg = s1_q.neg;
    s2_d.hi  = s1_q.sum_hi * s1_q.gain_mag;
    s2_d.lo  = s1_q.lo;
  end

  // Stage 3: combine with the magnitude cap, apply the sign, proportional term.
  assign p_sum = {1'b0, s2_q.hi[31:0], 32'd0} + {1'b0, s2_q.lo};
  assign p_cap = ((s2_q.hi[63:30] != '0) || (p_sum > gpfl_pkg::PROD_CAP))
                 ? gpfl_pkg::PROD_CAP : p_sum;
  always_comb begin
    s3_d.ctl   = s2_q.ctl;
    s3_d.integ = s2_q.neg ? (64'd0 - p_cap[63:0]) : p_cap[63:0];
    s3_d.prop  = 63'(s2_q.err) * 63'(cfg_i.gain_p);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) s1_q <= s1_d;
    if (r2 && v1_q)       s2_q <= s2_d;
    if (r3 && v2_q)       s3_q <= s3_d;
  end

endmodule

`default_nettype wire

@@ rtl/gpfl_out.sv @@
// Output stage: rounding, correction clamp, drive and hold offset, result register.
`default_nettype none

module gpfl_out (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire gpfl_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire gpfl_pkg::prod_t in_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic        [23:0]   out_data_o
);

  logic signed [14:0] drive_q, drive_d;
  logic signed [14:0] hold_q, hold_d;
  logic               valid_q;
  logic        [23:0] data_q, data_d;
  logic               load;

  logic signed [65:0] total;
  logic signed [41:0] corr_full, corr_hi, corr_lo, cmax, cmin;
  logic signed [14:0] corr;
  logic signed [15:0] fb_sum;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Floor of (x + half) / 2^24 rounds halves toward plus infinity.
  assign total     = 66'(in_i.integ) + 66'(in_i.prop) + gpfl_pkg::ROUND_HALF;
  assign corr_full = total[65:24];
  assign cmax      = 42'(cfg_i.corr_max);
  assign cmin      = 42'(cfg_i.corr_min);
  // The lower bound is applied last, so it wins when the bounds cross.
  assign corr_hi   = (corr_full > cmax) ? cmax : corr_full;
  assign corr_lo   = (corr_hi < cmin) ? cmin : corr_hi;
  assign corr      = corr_lo[14:0];
  assign fb_sum    = 16'(hold_q) + 16'(corr);

  always_comb begin
    drive_d = drive_q;
    hold_d  = hold_q;
    if (in_i.ctl.req == gpfl_pkg::REQ_MANUAL) begin
      drive_d = gpfl_pkg::sat_dac(16'(in_i.ctl.manual));
    end else if (in_i.ctl.applied) begin
      drive_d = gpfl_pkg::sat_dac(fb_sum);
    end
    if (in_i.ctl.capture) begin
      hold_d = drive_q;
    end
  end

  always_comb begin
    data_d = {5'd0, in_i.ctl.refused, in_i.ctl.applied, in_i.ctl.regulating,
              in_i.ctl.locked, drive_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
      hold_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        drive_q <= drive_d;
        hold_q  <= hold_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/gated_pi_frequency_lock.sv @@
// Top level of the gated PI laser frequency lock.
`default_nettype none

// Gated PI frequency lock. Each input transfer carries a request in s_axis_tuser
// (frequency sample, regulation on, regulation off, manual voltage) and yields exactly
// one result transfer with the drive voltage in mV and the lock, regulation, feedback
// and refusal flags. While regulation is on, a sample whose error from the setpoint is
// strictly inside the lock window raises a saturating good counter and adds the error
// to a saturating error sum; any other sample clears both. Once the counter reaches
// the settle count the drive becomes the captured hold offset plus the clamped PI
// correction (Q8.24 gains, rounded to the nearest mV, halves up), saturated to
// +-10000 mV. Turning regulation on captures the present drive as hold offset, or is
// refused when the error exceeds the window. The block accepts one transfer per clock
// cycle while the result stream does not stall, a rate set by the accept-stage update of
// the counter, sum and regulation state. Results pass the accept-stage, product and
// output registers; the 64 by 32 bit integral product is split into two 32-bit halves
// over two pipeline stages. The stages are elastic, so a new transfer is taken
// while a finished result waits in the output register. The user writes the APB port
// configuration only while no transfer is in flight; the block does not enforce it.

module gated_pi_frequency_lock #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned SUM_BITS   = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [29:0] freq_mhz, [44:30] manual_mv
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata   // [14:0] drive_mv, [15] locked,
                                          // [16] regulating, [17] feedback_applied,
                                          // [18] enable_refused
);

  gpfl_pkg::cfg_t     cfg;
  gpfl_pkg::stage_a_t stage_a;
  gpfl_pkg::prod_t    prod;
  logic               a_valid, a_ready;
  logic               p_valid, p_ready;

  gpfl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept stage: the loop-carried counter, error sum, regulation and lock state live here.
  gpfl_ctrl #(
    .COUNT_BITS (COUNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (gpfl_pkg::req_e'(s_axis_tuser)),
    .freq_i      (s_axis_tdata[29:0]),
    .manual_i    (s_axis_tdata[44:30]),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_o       (stage_a)
  );

  // Product pipeline: feed-forward only, no state carried between items.
  gpfl_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_i        (stage_a),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_o       (prod)
  );

  // Output stage: drive and hold offset are updated here, in item order.
  gpfl_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .in_i        (prod),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // The drive never leaves the DAC range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'sd10000 &&
                       $signed(m_axis_tdata[14:0]) >= -15'sd10000))
    else $error("drive outside DAC range");

  // Lock is only reported while regulating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[15] && !m_axis_tdata[16]))
    else $error("locked without regulation");

  // A refused enable neither applies feedback nor turns regulation on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[18]) |-> (!m_axis_tdata[17] && !m_axis_tdata[16]))
    else $error("refused enable with feedback or regulation");

  // With the output register empty the whole pipeline can take a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire
